// ===== hw/rtl/i2c_master_bit_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer assertion macros
// Shared concurrent assertion forms for the sequencer modules.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// Assertion checked on every rising clock edge while reset is released.
`define I2CM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion checked on every rising clock edge, reset included.
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Command codes, queue entry layout and sequence lengths.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Command codes as they arrive on the request type field.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_ACK   = 2'd3
  } cmd_e;

  localparam int unsigned StepW = 5;

  // Index of the final drive action of each command.
  localparam logic [StepW-1:0] START_LAST = StepW'(3);
  localparam logic [StepW-1:0] STOP_LAST  = StepW'(2);
  localparam logic [StepW-1:0] WRITE_LAST = StepW'(23);
  localparam logic [StepW-1:0] ACK_LAST   = StepW'(2);

  // Configuration register map.
  localparam int unsigned PaddrW         = 3;
  localparam logic        REG_HALF_PERIOD = 1'b0;
  localparam logic [15:0] HALF_PERIOD_RST = 16'd20;

  // One classified command waiting for the line sequencer.
  typedef struct packed {
    cmd_e             cmd;
    logic [7:0]       data;
    logic             sample;
    logic [StepW-1:0] last_step;
  } entry_t;

endpackage

// ===== hw/rtl/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// I2C master command front end
// Accepts command items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_sequencer_defines.svh"

module i2cm_front
  import i2cm_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] data_byte_i,
  input  logic       ack_sample_i,
  output logic       q_valid_o,
  output entry_t     q_entry_o,
  input  logic       pop_i
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  entry_t            new_entry;
  logic              push;

  // Classify the incoming item and fix its sequence length.
  always_comb begin
    new_entry.data   = data_byte_i;
    new_entry.sample = ack_sample_i;
    unique case (req_type_i)
      CMD_START: begin
        new_entry.cmd       = CMD_START;
        new_entry.last_step = START_LAST;
      end
      CMD_STOP: begin
        new_entry.cmd       = CMD_STOP;
        new_entry.last_step = STOP_LAST;
      end
      CMD_WRITE: begin
        new_entry.cmd       = CMD_WRITE;
        new_entry.last_step = WRITE_LAST;
      end
      default: begin
        new_entry.cmd       = CMD_ACK;
        new_entry.last_step = ACK_LAST;
      end
    endcase
  end

  assign in_ready_o = (count_q != CntW'(DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = mem_q[rd_ptr_q];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_entry;
    end
  end

  `I2CM_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(DEPTH), "queue overfilled")
  `I2CM_ASSERT(a_pop_nonempty, clk_i, rst_ni, pop_i |-> (count_q != '0), "pop from empty queue")
  `I2CM_ASSERT(a_push_count, clk_i, rst_ni, (push && !pop_i) |=> (count_q == $past(count_q) + CntW'(1)), "push lost")

endmodule

// ===== hw/rtl/i2cm_back.sv =====
// ----------------------------------------------------------------------------
// I2C master line sequencer back end
// Steps through each queued command and emits one drive result per cycle while results are taken.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_sequencer_defines.svh"

module i2cm_back
  import i2cm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_valid_i,
  input  entry_t q_entry_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output logic   scl_level_o,
  output logic   sda_level_o,
  output logic   hold_half_period_o,
  output logic   nack_o,
  output logic   last_o
);

  // Position inside one data bit of a write.
  typedef enum logic [1:0] {
    PH_DATA = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  entry_t           ent_q;
  logic             busy_q;
  logic [StepW-1:0] step_q;
  phase_e           phase_q;
  logic [7:0]       shreg_q;
  logic             scl_q, sda_q;
  logic             out_valid_q;
  logic             out_scl_q, out_sda_q, out_hold_q, out_nack_q, out_last_q;

  logic             scl_d, sda_d, hold_d, nack_d;
  logic             is_last, fire, pop;

  // Drive levels for the current action.
  always_comb begin
    scl_d  = scl_q;
    sda_d  = sda_q;
    hold_d = 1'b0;
    nack_d = 1'b0;
    unique case (ent_q.cmd)
      CMD_START: begin
        unique case (step_q[1:0])
          2'd0: sda_d = 1'b1;
          2'd1: begin
            scl_d  = 1'b1;
            hold_d = 1'b1;
          end
          2'd2: begin
            sda_d  = 1'b0;
            hold_d = 1'b1;
          end
          default: scl_d = 1'b0;
        endcase
      end
      CMD_STOP: begin
        unique case (step_q[1:0])
          2'd0: sda_d = 1'b0;
          2'd1: begin
            scl_d  = 1'b1;
            hold_d = 1'b1;
          end
          default: begin
            sda_d  = 1'b1;
            hold_d = 1'b1;
          end
        endcase
      end
      CMD_WRITE: begin
        unique case (phase_q)
          PH_DATA: sda_d = shreg_q[7];
          PH_HIGH: begin
            scl_d  = 1'b1;
            hold_d = 1'b1;
          end
          default: begin
            scl_d  = 1'b0;
            hold_d = 1'b1;
          end
        endcase
      end
      default: begin
        unique case (step_q[1:0])
          2'd0: sda_d = 1'b1;
          2'd1: begin
            scl_d  = 1'b1;
            hold_d = 1'b1;
          end
          default: begin
            scl_d  = 1'b0;
            nack_d = ent_q.sample;
          end
        endcase
      end
    endcase
  end

  // An action fires when the output register is free; the next command is
  // loaded in the same cycle the current one issues its final action.
  assign is_last = (step_q == ent_q.last_step);
  assign fire    = busy_q && (!out_valid_q || out_ready_i);
  assign pop     = q_valid_i && (!busy_q || (fire && is_last));
  assign pop_o   = pop;

  // Sequencer state, line state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q       <= '0;
      busy_q      <= 1'b0;
      step_q      <= '0;
      phase_q     <= PH_DATA;
      shreg_q     <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
      out_scl_q   <= 1'b1;
      out_sda_q   <= 1'b1;
      out_hold_q  <= 1'b0;
      out_nack_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        out_scl_q   <= scl_d;
        out_sda_q   <= sda_d;
        out_hold_q  <= hold_d;
        out_nack_q  <= nack_d;
        out_last_q  <= is_last;
        scl_q       <= scl_d;
        sda_q       <= sda_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // A newly loaded command takes over the step counters.
      if (pop) begin
        ent_q   <= q_entry_i;
        busy_q  <= 1'b1;
        step_q  <= '0;
        phase_q <= PH_DATA;
        shreg_q <= q_entry_i.data;
      end else if (fire) begin
        step_q <= step_q + StepW'(1);
        unique case (phase_q)
          PH_DATA: phase_q <= PH_HIGH;
          PH_HIGH: phase_q <= PH_LOW;
          default: begin
            phase_q <= PH_DATA;
            shreg_q <= {shreg_q[6:0], 1'b0};
          end
        endcase
        if (is_last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign scl_level_o        = out_scl_q;
  assign sda_level_o        = out_sda_q;
  assign hold_half_period_o = out_hold_q;
  assign nack_o             = out_nack_q;
  assign last_o             = out_last_q;

  `I2CM_ASSERT(a_busy_holds, clk_i, rst_ni, (fire && !is_last) |=> busy_q, "command dropped early")
  `I2CM_ASSERT(a_write_end, clk_i, rst_ni, (busy_q && ent_q.cmd == CMD_WRITE && is_last) |-> (phase_q == PH_LOW), "write ends mid bit")
  `I2CM_ASSERT(a_start_scl, clk_i, rst_ni, (fire && is_last && ent_q.cmd == CMD_START) |=> !scl_q, "start leaves SCL released")

endmodule

// ===== hw/rtl/i2c_master_bit_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// An item accepted into an idle block is written to the queue, loaded into the
// back end command register and then gives its first drive result from the
// output register. The back end gives one result per cycle while results are
// taken; start gives 4 results, stop 3, write 24 and acknowledge 3.
// Reset: both lines released, queue empty, half period register at 20.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
  import i2cm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Command items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        data_byte_i,
  input  logic              ack_sample_i,
  // Drive result items
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              scl_level_o,
  output logic              sda_level_o,
  output logic              hold_half_period_o,
  output logic              nack_o,
  output logic              last_o
);

  logic [15:0] half_period_q;
  logic        q_valid, pop;
  entry_t      q_entry;

  // Half period register; it is read back through the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RST;
    end else if (psel && penable && pwrite && paddr[PaddrW-1] == REG_HALF_PERIOD) begin
      half_period_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[PaddrW-1] == REG_HALF_PERIOD) ? {16'd0, half_period_q} : 32'd0;

  i2cm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .ack_sample_i (ack_sample_i),
    .q_valid_o    (q_valid),
    .q_entry_o    (q_entry),
    .pop_i        (pop)
  );

  i2cm_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_entry_i          (q_entry),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .scl_level_o        (scl_level_o),
    .sda_level_o        (sda_level_o),
    .hold_half_period_o (hold_half_period_o),
    .nack_o             (nack_o),
    .last_o             (last_o)
  );

endmodule

// ===== dv/i2c_master_bit_sequencer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Drives start, stop, write and acknowledge commands into the sequencer and
// predicts every SCL/SDA drive item from a line-level model of the master.
// Each accepted drive item is compared field by field with the oldest
// prediction. The half period register is rewritten between phases, and
// both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_test;
  import i2cm_pkg::*;

  // One predicted or observed drive action on the bus.
  typedef struct packed {
    logic scl;
    logic sda;
    logic hold;
    logic nack;
    logic last;
  } drive_t;

  localparam logic [PaddrW-1:0] HalfPeriodAddr = PaddrW'(4 * REG_HALF_PERIOD);

  // Line model of the master plus the queue of drive items still to come.
  class line_scoreboard;
    logic        scl_drive;
    logic        sda_drive;
    logic [15:0] half_period;
    drive_t      drive_q[$];
    int unsigned n_items;
    int unsigned n_drives;
    int unsigned n_errors;

    function new();
      scl_drive   = 1'b1;
      sda_drive   = 1'b1;
      half_period = HALF_PERIOD_RST;
    endfunction

    function void set_half_period(logic [15:0] ticks);
      half_period = ticks;
    endfunction

    function void push_drive(logic hold, logic nack, logic last);
      drive_q.push_back('{scl_drive, sda_drive, hold, nack, last});
    endfunction

    // Expand one accepted command into its drive actions.
    function void note_command(cmd_e cmd, logic [7:0] data, logic sample);
      n_items++;
      case (cmd)
        CMD_START: begin
          sda_drive = 1'b1; push_drive(1'b0, 1'b0, 1'b0);
          scl_drive = 1'b1; push_drive(1'b1, 1'b0, 1'b0);
          sda_drive = 1'b0; push_drive(1'b1, 1'b0, 1'b0);
          scl_drive = 1'b0; push_drive(1'b0, 1'b0, 1'b1);
        end
        CMD_STOP: begin
          sda_drive = 1'b0; push_drive(1'b0, 1'b0, 1'b0);
          scl_drive = 1'b1; push_drive(1'b1, 1'b0, 1'b0);
          sda_drive = 1'b1; push_drive(1'b1, 1'b0, 1'b1);
        end
        CMD_WRITE: begin
          // Most significant bit goes out first.
          for (int b = 7; b >= 0; b--) begin
            sda_drive = data[b]; push_drive(1'b0, 1'b0, 1'b0);
            scl_drive = 1'b1;    push_drive(1'b1, 1'b0, 1'b0);
            scl_drive = 1'b0;    push_drive(1'b1, 1'b0, b == 0);
          end
        end
        default: begin
          sda_drive = 1'b1; push_drive(1'b0, 1'b0, 1'b0);
          scl_drive = 1'b1; push_drive(1'b1, 1'b0, 1'b0);
          scl_drive = 1'b0; push_drive(1'b0, sample, 1'b1);
        end
      endcase
    endfunction

    // Compare one accepted drive item with the oldest prediction.
    function void check_drive(drive_t got);
      drive_t want;
      n_drives++;
      if (drive_q.size() == 0) begin
        $error("Drive item with nothing predicted: scl %0b sda %0b", got.scl, got.sda);
        n_errors++;
        return;
      end
      want = drive_q.pop_front();
      if (got.scl !== want.scl) begin
        $error("scl_level: expected %0b, got %0b", want.scl, got.scl);
        n_errors++;
      end
      if (got.sda !== want.sda) begin
        $error("sda_level: expected %0b, got %0b", want.sda, got.sda);
        n_errors++;
      end
      if (got.hold !== want.hold) begin
        $error("hold_half_period: expected %0b, got %0b", want.hold, got.hold);
        n_errors++;
      end
      if (got.nack !== want.nack) begin
        $error("nack: expected %0b, got %0b", want.nack, got.nack);
        n_errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        n_errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        req_type_i;
  logic [7:0]        data_byte_i;
  logic              ack_sample_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              scl_level_o;
  logic              sda_level_o;
  logic              hold_half_period_o;
  logic              nack_o;
  logic              last_o;

  line_scoreboard sb = new();
  bit             sender_gaps = 1'b1;
  bit             stall_done  = 1'b0;

  i2c_master_bit_sequencer DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .data_byte_i        (data_byte_i),
    .ack_sample_i       (ack_sample_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .scl_level_o        (scl_level_o),
    .sda_level_o        (sda_level_o),
    .hold_half_period_o (hold_half_period_o),
    .nack_o             (nack_o),
    .last_o             (last_o)
  );

  // 50 MHz clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // Write the half period register with junk in the unused upper bits.
  task automatic write_half_period(input logic [15:0] ticks);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HalfPeriodAddr;
    pwdata  <= {16'($urandom), ticks};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_half_period(ticks);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one command and hold it until the block takes it.
  task automatic send_command(input cmd_e cmd, input logic [7:0] data, input logic sample);
    if (sender_gaps) begin
      while ($urandom_range(99) < 8) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= cmd;
    data_byte_i  <= data;
    ack_sample_i <= sample;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(cmd, data, sample);
  endtask

  // Stop offering and wait until every predicted drive item has come out.
  task automatic drain_lines();
    in_valid_i <= 1'b0;
    while (sb.drive_q.size() != 0) @(posedge clk_i);
  endtask

  // Mostly complete write transfers with random content, some stray commands.
  task automatic run_transfers(input int unsigned n_cmds);
    int unsigned sent;
    int unsigned n_bytes;
    sent = 0;
    while (sent < n_cmds) begin
      if ($urandom_range(99) < 80) begin
        send_command(CMD_START, 8'($urandom), 1'($urandom));
        n_bytes = $urandom_range(1, 3);
        repeat (n_bytes) begin
          send_command(CMD_WRITE, 8'($urandom), 1'($urandom));
          send_command(CMD_ACK, 8'($urandom), ($urandom_range(99) < 25));
        end
        sent += 1 + 2 * n_bytes;
        // Now and then leave the bus held for a repeated start.
        if ($urandom_range(99) < 85) begin
          send_command(CMD_STOP, 8'($urandom), 1'($urandom));
          sent++;
        end
      end else begin
        send_command(cmd_e'($urandom_range(3)), 8'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  // Result side: check accepted drive items and pace out_ready_i.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_drive('{scl_level_o, sda_level_o, hold_half_period_o, nack_o, last_o});
      end
      // One long hold-off so the command queue fills and stalls the input.
      if (!stall_done && sb.n_items >= 50) begin
        stall_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      if (sb.n_drives >= 1000 && sb.n_drives < 1400) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 8);
      end
    end
  end

  // Stimulus.
  initial begin
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid_i   <= 1'b0;
    req_type_i   <= '0;
    data_byte_i  <= '0;
    ack_sample_i <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Half period of one, then fixed command sequences.
    write_half_period(16'd1);
    // Stop on a released bus: the first action leaves SCL unchanged.
    send_command(CMD_STOP, 8'h00, 1'b0);
    send_command(CMD_START, 8'hFF, 1'b1);
    send_command(CMD_WRITE, 8'h00, 1'b1);
    send_command(CMD_ACK, 8'hFF, 1'b0);
    send_command(CMD_WRITE, 8'hFF, 1'b0);
    send_command(CMD_ACK, 8'h00, 1'b1);
    send_command(CMD_WRITE, 8'hA5, 1'b0);
    send_command(CMD_WRITE, 8'h5A, 1'b1);
    send_command(CMD_WRITE, 8'h80, 1'b0);
    send_command(CMD_WRITE, 8'h01, 1'b0);
    // Repeated start without a stop in between.
    send_command(CMD_START, 8'h00, 1'b0);
    send_command(CMD_START, 8'h00, 1'b0);
    send_command(CMD_STOP, 8'hFF, 1'b1);
    send_command(CMD_STOP, 8'hFF, 1'b1);
    // Commands out of protocol order on an idle bus.
    send_command(CMD_ACK, 8'h3C, 1'b1);
    send_command(CMD_WRITE, 8'hC3, 1'b1);
    send_command(CMD_ACK, 8'h00, 1'b0);
    send_command(CMD_STOP, 8'h00, 1'b0);
    drain_lines();

    // Longest half period.
    write_half_period(16'hFFFF);
    run_transfers(45);
    drain_lines();

    // Zero half period, with the input kept busy throughout.
    write_half_period(16'd0);
    sender_gaps = 1'b0;
    run_transfers(45);
    sender_gaps = 1'b1;
    drain_lines();

    // Back to the reset value, then a random setting.
    write_half_period(HALF_PERIOD_RST);
    run_transfers(20);
    drain_lines();
    write_half_period(16'($urandom_range(2, 65534)));
    run_transfers(25);
    drain_lines();

    repeat (20) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.drive_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
